@@ rtl/core/multichannel_sample_histogram_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the histogram core.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SAMPLE_HISTOGRAM_CORE_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_HISTOGRAM_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSHC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MSHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram core assertion failed");

`endif

@@ rtl/core/mshc_pkg.sv @@
// ----------------------------------------------------------------------------
// mshc_pkg
// Types, sizes, codes and helpers shared by the histogram core.
// ----------------------------------------------------------------------------
`default_nettype none

package mshc_pkg;

    // Store geometry.
    localparam int CHANNELS  = 64;
    localparam int BINS      = 4096;
    localparam int CH_W      = $clog2(CHANNELS);
    localparam int BIN_W     = $clog2(BINS);
    localparam int ADDR_W    = CH_W + BIN_W;
    localparam int MEM_DEPTH = CHANNELS * BINS;

    // Counters.
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(100);

    // Action codes of an input word.
    localparam int ACT_W = 2;
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RANGE = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_READ_DONE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_RANGE_DONE
    } mshc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic item_ld;
        logic add_wr;
        logic scan_start;
        logic scan_rd;
        logic out_ld_read;
        logic out_ld_range;
    } mshc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic out_free;
    } mshc_sts_t;

    // Saturating increment of a counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mshc_if.sv @@
// ----------------------------------------------------------------------------
// mshc_in_if / mshc_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface mshc_in_if;
    import mshc_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [CH_W-1:0]  channel;
    logic [BIN_W-1:0] sample_value;
    logic             sample_end;

    modport source (output valid, action, channel, sample_value, sample_end,
                    input ready);
    modport sink   (input valid, action, channel, sample_value, sample_end,
                    output ready);
endinterface

interface mshc_out_if;
    import mshc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] bin_count;
    logic [CNT_W-1:0] samples_seen;
    logic [BIN_W-1:0] low_bin;
    logic [BIN_W-1:0] high_bin;
    logic             range_empty;

    modport source (output valid, bin_count, samples_seen, low_bin, high_bin,
                    range_empty, input ready);
    modport sink   (input valid, bin_count, samples_seen, low_bin, high_bin,
                    range_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mshc_controller.sv @@
// ----------------------------------------------------------------------------
// mshc_controller
// Sequencer for the clearing sweep, add, read and range scan operations.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multichannel_sample_histogram_core_defines.svh"

module mshc_controller (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [mshc_pkg::ACT_W-1:0] in_action,
    output logic                           in_ready,
    input  wire mshc_pkg::mshc_sts_t       sts,
    output mshc_pkg::mshc_cmd_t            cmd
);
    import mshc_pkg::*;

    mshc_state_t state_reg;
    mshc_state_t state_next;

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (in_action)
                        ACT_ADD:
                        begin
                            cmd.item_ld = 1'b1;
                            state_next  = ST_ADD_WR;
                        end
                        ACT_READ:
                        begin
                            cmd.item_ld = 1'b1;
                            state_next  = ST_READ_DONE;
                        end
                        ACT_RANGE:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        default:
                        begin
                            // An unused action is taken and dropped.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld_read = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                // The last bin total is compared in this cycle.
                state_next = ST_RANGE_DONE;
            end
            ST_RANGE_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld_range = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is only loaded into a free output register.
    `MSHC_ASSERT_SAME(a_out_ld_free, clk, rst_n, cmd.out_ld_read || cmd.out_ld_range, sts.out_free)
    // Every add write follows the load that read its old counts.
    `MSHC_ASSERT_SAME(a_add_after_load, clk, rst_n, cmd.add_wr, $past(cmd.item_ld))
    // The scan drains only after its last bin address was issued.
    `MSHC_ASSERT_SAME(a_drain_after_last, clk, rst_n, state_reg == ST_SCAN_DRAIN, $past(sts.scan_last))
    // No word is taken while the clearing sweep runs.
    `MSHC_ASSERT_SAME(a_no_take_in_clear, clk, rst_n, cmd.clr_wr, !in_ready)

endmodule

`default_nettype wire

@@ rtl/core/mshc_datapath.sv @@
// ----------------------------------------------------------------------------
// mshc_datapath
// Count memories, sample counter, range scan registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mshc_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mshc_pkg::mshc_cmd_t        cmd,
    output mshc_pkg::mshc_sts_t             sts,
    input  wire logic [mshc_pkg::CH_W-1:0]  in_channel,
    input  wire logic [mshc_pkg::BIN_W-1:0] in_sample_value,
    input  wire logic                       in_sample_end,
    input  wire logic                       cfg_wr_en,
    input  wire logic [mshc_pkg::CNT_W-1:0] cfg_wr_data,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [mshc_pkg::CNT_W-1:0]      out_bin_count,
    output logic [mshc_pkg::CNT_W-1:0]      out_samples_seen,
    output logic [mshc_pkg::BIN_W-1:0]      out_low_bin,
    output logic [mshc_pkg::BIN_W-1:0]      out_high_bin,
    output logic                            out_range_empty
);
    import mshc_pkg::*;

    // Memories: per channel and bin counts, and per bin totals.
    logic [CNT_W-1:0] ch_mem  [MEM_DEPTH];
    logic [CNT_W-1:0] tot_mem [BINS];

    logic [CNT_W-1:0]  ch_rd_reg;
    logic [CNT_W-1:0]  tot_rd_reg;
    logic [ADDR_W-1:0] item_addr_reg;
    logic              item_end_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [BIN_W-1:0]  scan_addr_reg;
    logic              cmp_valid_reg;
    logic [BIN_W-1:0]  cmp_bin_reg;
    logic              found_reg;
    logic [BIN_W-1:0]  lo_reg;
    logic [BIN_W-1:0]  hi_reg;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [CNT_W-1:0]  threshold_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_bin_count_reg;
    logic [CNT_W-1:0]  out_samples_reg;
    logic [BIN_W-1:0]  out_low_reg;
    logic [BIN_W-1:0]  out_high_reg;
    logic              out_empty_reg;

    logic              ch_we;
    logic [ADDR_W-1:0] ch_waddr;
    logic [CNT_W-1:0]  ch_wdata;
    logic [BIN_W-1:0]  tot_waddr;
    logic [CNT_W-1:0]  tot_wdata;
    logic [BIN_W-1:0]  tot_raddr;
    logic              tot_re;
    logic              hit;

    // Write and read port selection.
    always_comb
    begin
        ch_we     = cmd.clr_wr || cmd.add_wr;
        ch_waddr  = cmd.clr_wr ? clr_addr_reg : item_addr_reg;
        ch_wdata  = cmd.clr_wr ? '0 : sat_inc(ch_rd_reg);
        tot_waddr = cmd.clr_wr ? clr_addr_reg[BIN_W-1:0] : item_addr_reg[BIN_W-1:0];
        tot_wdata = cmd.clr_wr ? '0 : sat_inc(tot_rd_reg);
        tot_raddr = cmd.scan_rd ? scan_addr_reg : in_sample_value;
        tot_re    = cmd.scan_rd || cmd.item_ld;
        hit       = cmp_valid_reg && (tot_rd_reg > threshold_reg);
    end

    // Channel count memory, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            ch_mem[ch_waddr] <= ch_wdata;
        end
        if (cmd.item_ld)
        begin
            ch_rd_reg <= ch_mem[{in_channel, in_sample_value}];
        end
    end

    // Bin total memory, one write and one registered read.
    always_ff @(posedge clk)
    begin
        if (ch_we)
        begin
            tot_mem[tot_waddr] <= tot_wdata;
        end
        if (tot_re)
        begin
            tot_rd_reg <= tot_mem[tot_raddr];
        end
    end

    // Latched item address and range scan bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.item_ld)
        begin
            item_addr_reg <= {in_channel, in_sample_value};
            item_end_reg  <= in_sample_end;
        end
        if (cmd.scan_rd)
        begin
            cmp_bin_reg <= scan_addr_reg;
        end
        if (cmd.scan_start)
        begin
            lo_reg <= '0;
            hi_reg <= '0;
        end
        else if (hit)
        begin
            hi_reg <= cmp_bin_reg;
            if (!found_reg)
            begin
                lo_reg <= cmp_bin_reg;
            end
        end
    end

    // Control counters, flags and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            scan_addr_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            found_reg        <= 1'b0;
            sample_count_reg <= '0;
            threshold_reg    <= THRESHOLD_RESET;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (cmd.scan_rd)
                begin
                    scan_addr_reg <= scan_addr_reg + BIN_W'(1);
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
            end
            cmp_valid_reg <= cmd.scan_rd;
            if (cmd.add_wr && item_end_reg)
            begin
                sample_count_reg <= sat_inc(sample_count_reg);
            end
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld_read || cmd.out_ld_range)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld_read)
        begin
            out_bin_count_reg <= ch_rd_reg;
            out_samples_reg   <= sample_count_reg;
            out_low_reg       <= '0;
            out_high_reg      <= '0;
            out_empty_reg     <= 1'b0;
        end
        else if (cmd.out_ld_range)
        begin
            out_bin_count_reg <= '0;
            out_samples_reg   <= sample_count_reg;
            out_low_reg       <= lo_reg;
            out_high_reg      <= hi_reg;
            out_empty_reg     <= !found_reg;
        end
    end

    // Status back to the controller.
    always_comb
    begin
        sts.clr_last  = (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1));
        sts.scan_last = (scan_addr_reg == BIN_W'(BINS - 1));
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid        = out_valid_reg;
    assign out_bin_count    = out_bin_count_reg;
    assign out_samples_seen = out_samples_reg;
    assign out_low_bin      = out_low_reg;
    assign out_high_bin     = out_high_reg;
    assign out_range_empty  = out_empty_reg;

endmodule

`default_nettype wire

@@ rtl/core/multichannel_sample_histogram_core.sv @@
// ----------------------------------------------------------------------------
// multichannel_sample_histogram_core
// Per-channel value histograms with all-channel bin totals and range search.
// ----------------------------------------------------------------------------
// Input words arrive on sample_in (valid/ready). An add word bumps one channel
// bin and its all-channel total and, with sample_end set, the sample count.
// A read word returns one channel bin count with the sample count, and a range
// word returns the lowest and highest bin whose total exceeds the threshold.
// Result words leave on result_out (valid/ready); an add gives no result.
// cfg_wr_en with cfg_wr_data writes the occupancy threshold (reset 100).
// An add is a read-modify-write on both count memories, a read registers the
// channel count and loads it into the output register once that is free, and
// a range search reads one bin total a cycle from the single read port of the
// total memory. One word is worked on at a time.
// After reset a clearing sweep zeroes both memories, one channel count entry
// a cycle, all CHANNELS * BINS = 262144 of them, while no word is taken.
// When the receiver stalls, the result waits in the output register; further
// add words are still taken, and a following read or range waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module multichannel_sample_histogram_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    mshc_in_if.sink                         sample_in,
    mshc_out_if.source                      result_out,
    input  wire logic                       cfg_wr_en,
    input  wire logic [mshc_pkg::CNT_W-1:0] cfg_wr_data
);
    import mshc_pkg::*;

    mshc_cmd_t cmd;
    mshc_sts_t sts;

    // Sequencer.
    mshc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_action (sample_in.action),
        .in_ready  (sample_in.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Memories, counters and result register.
    mshc_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .in_channel       (sample_in.channel),
        .in_sample_value  (sample_in.sample_value),
        .in_sample_end    (sample_in.sample_end),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .out_ready        (result_out.ready),
        .out_valid        (result_out.valid),
        .out_bin_count    (result_out.bin_count),
        .out_samples_seen (result_out.samples_seen),
        .out_low_bin      (result_out.low_bin),
        .out_high_bin     (result_out.high_bin),
        .out_range_empty  (result_out.range_empty)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel sample histogram core.
// ----------------------------------------------------------------------------
// Words go in on a valid/ready channel with random gaps. A behavioural copy of
// the histogram store predicts every read and range result, and each result
// word is checked field by field against the oldest prediction. A directed
// table comes first, then phases of random words under several thresholds.
// The result side stalls at random and once holds off for a long stretch, so
// that the core backs up and refuses input words.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mshc_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned LIMIT_CYCLES     = 3_000_000;
    localparam int unsigned SETTLE_CYCLES    = 10;
    localparam int unsigned TAIL_CYCLES      = 20;
    localparam int unsigned HOLD_AFTER_WORDS = 400;
    localparam int unsigned LONG_HOLD_CYCLES = 600;
    localparam int unsigned PHASE_WORDS      = 200;
    localparam int unsigned PHASES           = 5;
    localparam int unsigned HOT_BINS         = 6;
    localparam int unsigned RECENT_DEPTH     = 64;
    localparam int unsigned REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [CH_W-1:0]  channel;
        logic [BIN_W-1:0] sample_value;
        logic             sample_end;
    } hist_word_t;

    typedef struct packed {
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] samples_seen;
        logic [BIN_W-1:0] low_bin;
        logic [BIN_W-1:0] high_bin;
        logic             range_empty;
    } hist_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_THRESHOLD
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        hist_word_t       word;
        logic [CNT_W-1:0] threshold;
        bit               typed;
        hist_result_t     typed_res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;

    mshc_in_if  sample_in ();
    mshc_out_if result_out ();

    multichannel_sample_histogram_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_in   (sample_in),
        .result_out  (result_out),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Shadow copy of the histogram store and the threshold register.
    logic [CNT_W-1:0] chan_counts [int unsigned];
    logic [CNT_W-1:0] bin_totals [BINS] = '{default: '0};
    logic [CNT_W-1:0] sample_total = '0;
    logic [CNT_W-1:0] occ_threshold = THRESHOLD_RESET;

    hist_result_t pending_results [$];
    stim_row_t    stim_tab [$];
    hist_word_t   recent_adds [$];
    logic [BIN_W-1:0] hot_bins [HOT_BINS];

    int unsigned words_taken = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_add = 0;
    int unsigned n_read = 0;
    int unsigned n_range = 0;
    int unsigned n_range_found = 0;
    int unsigned n_unused = 0;
    int unsigned n_thresholds = 0;
    bit          long_hold_done = 1'b0;
    int unsigned send_stretch_left = 0;
    bit          send_no_idle = 1'b0;

    // Free-running clock, 20 ns period.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Saturating counter step.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Applies one word to the shadow store; returns 1 with the result it gives.
    function automatic bit histogram_step(input hist_word_t wd, output hist_result_t res);
        int unsigned key;
        bit found;
        key = 32'({wd.channel, wd.sample_value});
        res = '0;
        found = 1'b0;
        case (wd.action)
            ACT_ADD:
            begin
                chan_counts[key] = bump(chan_counts.exists(key) ? chan_counts[key] : '0);
                bin_totals[wd.sample_value] = bump(bin_totals[wd.sample_value]);
                if (wd.sample_end)
                    sample_total = bump(sample_total);
                return 1'b0;
            end
            ACT_READ:
            begin
                res.bin_count = chan_counts.exists(key) ? chan_counts[key] : '0;
                res.samples_seen = sample_total;
                return 1'b1;
            end
            ACT_RANGE:
            begin
                res.samples_seen = sample_total;
                for (int b = 0; b < BINS; b++)
                begin
                    if (bin_totals[b] > occ_threshold)
                    begin
                        if (!found)
                            res.low_bin = BIN_W'(b);
                        res.high_bin = BIN_W'(b);
                        found = 1'b1;
                    end
                end
                res.range_empty = !found;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Table builders for the directed part.
    function automatic void tab_word(input logic [ACT_W-1:0] act, input int unsigned ch,
                                     input int unsigned val, input bit last);
        stim_row_t row;
        row.kind = ROW_WORD;
        row.word = '{act, CH_W'(ch), BIN_W'(val), last};
        row.threshold = '0;
        row.typed = 1'b0;
        row.typed_res = '0;
        stim_tab.push_back(row);
    endfunction

    function automatic void tab_typed(input logic [ACT_W-1:0] act, input int unsigned ch,
                                      input int unsigned val, input int unsigned cnt,
                                      input int unsigned seen, input int unsigned lo,
                                      input int unsigned hi, input bit empty);
        stim_row_t row;
        row.kind = ROW_WORD;
        row.word = '{act, CH_W'(ch), BIN_W'(val), 1'b0};
        row.threshold = '0;
        row.typed = 1'b1;
        row.typed_res = '{CNT_W'(cnt), CNT_W'(seen), BIN_W'(lo), BIN_W'(hi), empty};
        stim_tab.push_back(row);
    endfunction

    function automatic void tab_threshold(input logic [CNT_W-1:0] value);
        stim_row_t row;
        row.kind = ROW_THRESHOLD;
        row.word = '0;
        row.threshold = value;
        row.typed = 1'b0;
        row.typed_res = '0;
        stim_tab.push_back(row);
    endfunction

    // Idle cycles before the next input word: stretches without gaps, else
    // mostly short gaps with the odd long one.
    function automatic int unsigned next_gap();
        int unsigned r;
        if (send_stretch_left == 0)
        begin
            send_stretch_left = $urandom_range(10, 60);
            send_no_idle = ($urandom_range(0, 3) == 0);
        end
        send_stretch_left--;
        if (send_no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random word: adds lean on a few hot bins so that totals pass the
    // threshold, and reads mostly revisit channel/bin pairs already added.
    function automatic hist_word_t random_word();
        hist_word_t w;
        int unsigned r;
        int unsigned pick;
        w.channel = CH_W'($urandom_range(0, CHANNELS - 1));
        w.sample_value = BIN_W'($urandom_range(0, BINS - 1));
        w.sample_end = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            w.action = ACT_ADD;
            if ($urandom_range(0, 9) < 7)
                w.sample_value = hot_bins[$urandom_range(0, HOT_BINS - 1)];
        end
        else if (r < 92)
        begin
            w.action = ACT_READ;
            if (recent_adds.size() != 0 && $urandom_range(0, 9) < 6)
            begin
                pick = $urandom_range(0, recent_adds.size() - 1);
                w.channel = recent_adds[pick].channel;
                w.sample_value = recent_adds[pick].sample_value;
            end
        end
        else if (r < 96)
            w.action = ACT_RANGE;
        else
            w.action = ACT_UNUSED;
        return w;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Offers one word after a gap and waits until the core takes it.
    task automatic send_word(input hist_word_t wd, input int unsigned gap,
                             input bit typed, input hist_result_t typed_res);
        hist_result_t res;
        bit has_res;
        @(negedge clk);
        if (gap != 0)
        begin
            sample_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_in.action = wd.action;
        sample_in.channel = wd.channel;
        sample_in.sample_value = wd.sample_value;
        sample_in.sample_end = wd.sample_end;
        sample_in.valid = 1'b1;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        words_taken++;
        has_res = histogram_step(wd, res);
        if (has_res)
            pending_results.push_back(typed ? typed_res : res);
        case (wd.action)
            ACT_ADD:
            begin
                n_add++;
                recent_adds.push_back(wd);
                if (recent_adds.size() > RECENT_DEPTH)
                    void'(recent_adds.pop_front());
            end
            ACT_READ:  n_read++;
            ACT_RANGE:
            begin
                n_range++;
                if (!res.range_empty)
                    n_range_found++;
            end
            default:   n_unused++;
        endcase
    endtask

    // Threshold writes happen only once the core has gone quiet.
    task automatic write_threshold(input logic [CNT_W-1:0] value);
        @(negedge clk);
        sample_in.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        occ_threshold = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        n_thresholds++;
    endtask

    // Result receiver: random stalls in stretches, plus one long hold-off once
    // enough words have gone in.
    initial
    begin : result_sink
        int unsigned r;
        int unsigned stretch_left;
        bit no_stall;
        result_out.ready = 1'b0;
        stretch_left = 0;
        no_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && words_taken >= HOLD_AFTER_WORDS)
            begin
                result_out.ready = 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(20, 80);
                    no_stall = ($urandom_range(0, 3) == 0);
                end
                stretch_left--;
                r = $urandom_range(0, 99);
                if (no_stall || r < 70)
                    result_out.ready = 1'b1;
                else if (r < 96)
                    result_out.ready = 1'b0;
                else
                begin
                    result_out.ready = 1'b0;
                    repeat ($urandom_range(10, 50)) @(negedge clk);
                end
            end
        end
    end

    // Result checker: every accepted result word against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        hist_result_t got;
        hist_result_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            got = '{result_out.bin_count, result_out.samples_seen, result_out.low_bin,
                    result_out.high_bin, result_out.range_empty};
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result word %p", got));
            else
            begin
                want = pending_results.pop_front();
                if (got.bin_count !== want.bin_count
                    || got.samples_seen !== want.samples_seen
                    || got.low_bin !== want.low_bin
                    || got.high_bin !== want.high_bin
                    || got.range_empty !== want.range_empty)
                    note_failure($sformatf(
                        "cnt %0d/%0d seen %0d/%0d lo %0d/%0d hi %0d/%0d empty %0b/%0b (exp/act)",
                        want.bin_count, got.bin_count, want.samples_seen, got.samples_seen,
                        want.low_bin, got.low_bin, want.high_bin, got.high_bin,
                        want.range_empty, got.range_empty));
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin : stimulus
        logic [CNT_W-1:0] phase_thresholds [PHASES];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        sample_in.valid = 1'b0;
        sample_in.action = ACT_ADD;
        sample_in.channel = '0;
        sample_in.sample_value = '0;
        sample_in.sample_end = 1'b0;

        // Directed part: empty store, field extremes, every action and the
        // threshold extremes.
        tab_typed(ACT_RANGE, 0, 0, 0, 0, 0, 0, 1'b1);
        tab_typed(ACT_READ, 0, 0, 0, 0, 0, 0, 1'b0);
        tab_typed(ACT_READ, CHANNELS - 1, BINS - 1, 0, 0, 0, 0, 1'b0);
        tab_word(ACT_ADD, CHANNELS - 1, BINS - 1, 1'b1);
        tab_word(ACT_ADD, 0, 0, 1'b0);
        tab_word(ACT_ADD, 0, 0, 1'b1);
        tab_word(ACT_READ, 0, 0, 1'b0);
        tab_word(ACT_READ, CHANNELS - 1, BINS - 1, 1'b1);
        tab_word(ACT_UNUSED, CHANNELS - 1, BINS - 1, 1'b1);
        tab_word(ACT_READ, CHANNELS - 1, BINS - 1, 1'b0);
        tab_typed(ACT_RANGE, 0, 0, 0, 2, 0, 0, 1'b1);
        tab_threshold('1);
        tab_typed(ACT_RANGE, CHANNELS - 1, BINS - 1, 0, 2, 0, 0, 1'b1);
        tab_threshold('0);
        tab_typed(ACT_RANGE, 0, 0, 0, 2, 0, BINS - 1, 1'b0);
        tab_word(ACT_ADD, 42, 'h555, 1'b0);
        tab_word(ACT_ADD, 21, 'hAAA, 1'b1);
        tab_word(ACT_RANGE, 0, 0, 1'b0);
        tab_threshold(1);
        tab_word(ACT_ADD, 5, 0, 1'b0);
        tab_word(ACT_RANGE, 0, 0, 1'b1);
        tab_word(ACT_READ, 42, 'h555, 1'b0);
        tab_word(ACT_READ, 21, 'hAAA, 1'b1);
        tab_word(ACT_UNUSED, 0, 0, 1'b0);

        phase_thresholds = '{2, 25, '1, '0, '0};
        phase_thresholds[PHASES - 1] = $urandom_range(0, 60);
        foreach (hot_bins[i])
            hot_bins[i] = BIN_W'($urandom_range(0, BINS - 1));

        // Hold reset, then release it; the core then clears its store by itself.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stim_tab[i])
        begin
            if (stim_tab[i].kind == ROW_THRESHOLD)
                write_threshold(stim_tab[i].threshold);
            else
                send_word(stim_tab[i].word, next_gap(), stim_tab[i].typed,
                          stim_tab[i].typed_res);
        end

        // Random phases, each under its own threshold.
        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(phase_thresholds[p]);
            repeat (PHASE_WORDS)
                send_word(random_word(), next_gap(), 1'b0, '0);
        end

        @(negedge clk);
        sample_in.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d add, %0d read and %0d unused-action words, %0d range scans",
                 n_add, n_read, n_unused, n_range);
        $display("(%0d with an occupied range) under %0d threshold settings, in %0d cycles.",
                 n_range_found, n_thresholds, cycle_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
